[rtl/crcdf_pkg.sv]
// ----------------------------------------------------------------------------
// crcdf_pkg
// Shared constants, types and the CRC-16/CCITT byte update for the deframer.
// ----------------------------------------------------------------------------
package crcdf_pkg;

  localparam int MAX_PAYLOAD = 64;
  localparam int ADDR_W      = $clog2(MAX_PAYLOAD);
  localparam int LEN_W       = 7;
  localparam int BYTE_W      = 8;
  localparam int CRC_W       = 16;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 8;

  localparam logic [LEN_W-1:0]  MAX_LEN       = LEN_W'(MAX_PAYLOAD);
  localparam logic [CRC_W-1:0]  CRC_POLY      = 16'h1021;
  localparam logic [CRC_W-1:0]  CRC_INIT      = 16'hFFFF;
  localparam logic [BYTE_W-1:0] SYNC_RESET    = 8'd170;
  localparam logic [LEN_W-1:0]  MAX_LEN_RESET = 7'd64;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_VALUE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LENGTH = 1'b1;

  // Commands from controller to datapath
  typedef struct packed {
    logic crc_init;
    logic crc_upd;
    logic cap_cmd;
    logic cap_seq;
    logic cap_len;
    logic fill_clr;
    logic fill_wr;
    logic rel_clr;
    logic rel_adv;
    logic out_load;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic sync_hit;
    logic len_bad;
    logic new_len_zero;
    logic len_zero;
    logic fill_done;
    logic crc_lo_ok;
    logic crc_hi_ok;
    logic rel_last;
  } sts_t;

  // One byte of CRC-16/CCITT, MSB first
  function automatic logic [CRC_W-1:0] crc_step(input logic [CRC_W-1:0] crc,
                                                input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[CRC_W-1]) begin
        c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[CRC_W-2:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

[rtl/crc16_packet_deframer.sv]
// Release: after a good frame's high CRC byte is accepted, the first result
//   beat follows S_READ and S_LOAD in S_SHOW (S_LOAD only for zero length).
// Throughput: one received byte per cycle while parsing. In release, each beat
//   runs S_READ (registered RAM read), S_LOAD, then S_SHOW until not stalled.
// Reset (rst, synchronous, active high): hunt for sync, config at 170 / 64.
// ----------------------------------------------------------------------------
// crc16_packet_deframer
// Byte-serial deframer: sync, command, sequence, LE length, payload and an LE
// CRC-16/CCITT; good frames are released from the payload buffer per byte.
// ----------------------------------------------------------------------------
module crc16_packet_deframer
  import crcdf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // configuration write port
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // received byte channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [BYTE_W-1:0]     rx_byte,
  // result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [BYTE_W-1:0]     command,
  output logic [BYTE_W-1:0]     sequence_res,
  output logic [LEN_W-1:0]      payload_length,
  output logic [ADDR_W-1:0]     byte_index,
  output logic [BYTE_W-1:0]     data,
  output logic                  last
);

  // The controller walks the frame phases and, for a good frame, sequences
  // the release: read the buffer, load the result register, hold it until
  // the beat is taken. The input side stalls for the whole release.
  cmd_t cmd;
  sts_t sts;

  crcdf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // The datapath holds the config registers, header fields, running CRC,
  // the payload buffer and the outgoing data/last register. Header fields
  // are not touched during release, so they drive the result ports directly.
  crcdf_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .rx_byte        (rx_byte),
    .cmd            (cmd),
    .sts            (sts),
    .command        (command),
    .sequence_res   (sequence_res),
    .payload_length (payload_length),
    .byte_index     (byte_index),
    .data           (data),
    .last           (last)
  );

endmodule

[rtl/crcdf_ram.sv]
// ----------------------------------------------------------------------------
// crcdf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module crcdf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/crcdf_dp.sv]
// ----------------------------------------------------------------------------
// crcdf_dp
// Deframer datapath: config registers, header capture, CRC, payload buffer
// and the result register.
// ----------------------------------------------------------------------------
module crcdf_dp
  import crcdf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [BYTE_W-1:0]     rx_byte,
  input  cmd_t                  cmd,
  output sts_t                  sts,
  output logic [BYTE_W-1:0]     command,
  output logic [BYTE_W-1:0]     sequence_res,
  output logic [LEN_W-1:0]      payload_length,
  output logic [ADDR_W-1:0]     byte_index,
  output logic [BYTE_W-1:0]     data,
  output logic                  last
);

  logic [BYTE_W-1:0] sync_value;
  logic [LEN_W-1:0]  max_length;
  logic [CRC_W-1:0]  crc;
  logic [BYTE_W-1:0] cur_command;
  logic [BYTE_W-1:0] cur_sequence;
  logic [BYTE_W-1:0] len_lo;
  logic [LEN_W-1:0]  fill_index;
  logic [ADDR_W-1:0] rel_idx;
  logic [BYTE_W-1:0] data_q;
  logic              last_q;
  logic [BYTE_W-1:0] ram_rdata;
  logic [LEN_W-1:0]  limit;
  logic [15:0]       new_len;
  logic [LEN_W-1:0]  cur_len;

  assign limit   = (max_length > MAX_LEN) ? MAX_LEN : max_length;
  assign new_len = {rx_byte, len_lo};
  // accepted frames never exceed the limit, so the low bits are the length
  assign cur_len = len_lo[LEN_W-1:0];

  always_comb begin
    sts.sync_hit     = (rx_byte == sync_value);
    sts.len_bad      = (new_len > {{(16-LEN_W){1'b0}}, limit});
    sts.new_len_zero = (new_len == 16'd0);
    sts.len_zero     = (cur_len == '0);
    sts.fill_done    = ((fill_index + LEN_W'(1)) >= cur_len);
    sts.crc_lo_ok    = (rx_byte == crc[7:0]);
    sts.crc_hi_ok    = (rx_byte == crc[15:8]);
    sts.rel_last     = (cur_len == '0) || (({1'b0, rel_idx} + LEN_W'(1)) == cur_len);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_value <= SYNC_RESET;
      max_length <= MAX_LEN_RESET;
      crc        <= CRC_INIT;
      fill_index <= '0;
      rel_idx    <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_SYNC_VALUE: sync_value <= cfg_data;
          REG_MAX_LENGTH: max_length <= cfg_data[LEN_W-1:0];
          default: ;
        endcase
      end
      if (cmd.crc_init) begin
        crc <= CRC_INIT;
      end else if (cmd.crc_upd) begin
        crc <= crc_step(crc, rx_byte);
      end
      if (cmd.fill_clr) begin
        fill_index <= '0;
      end else if (cmd.fill_wr) begin
        fill_index <= fill_index + LEN_W'(1);
      end
      if (cmd.rel_clr) begin
        rel_idx <= '0;
      end else if (cmd.rel_adv) begin
        rel_idx <= rel_idx + ADDR_W'(1);
      end
    end
  end

  // Payload registers: no reset
  always_ff @(posedge clk) begin
    if (cmd.cap_cmd) begin
      cur_command <= rx_byte;
    end
    if (cmd.cap_seq) begin
      cur_sequence <= rx_byte;
    end
    if (cmd.cap_len) begin
      len_lo <= rx_byte;
    end
    if (cmd.out_load) begin
      data_q <= sts.len_zero ? '0 : ram_rdata;
      last_q <= sts.rel_last;
    end
  end

  crcdf_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (MAX_PAYLOAD)
  ) u_buf (
    .clk   (clk),
    .we    (cmd.fill_wr),
    .waddr (fill_index[ADDR_W-1:0]),
    .wdata (rx_byte),
    .raddr (rel_idx),
    .rdata (ram_rdata)
  );

  assign command        = cur_command;
  assign sequence_res   = cur_sequence;
  assign payload_length = cur_len;
  assign byte_index     = rel_idx;
  assign data           = data_q;
  assign last           = last_q;

endmodule

[rtl/crcdf_ctrl.sv]
// ----------------------------------------------------------------------------
// crcdf_ctrl
// Deframer controller: frame phase tracking and result release sequencing.
// ----------------------------------------------------------------------------
module crcdf_ctrl
  import crcdf_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  output logic out_valid,
  input  logic out_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [3:0] {
    S_SYNC, S_CMD, S_SEQ, S_LEN_LO, S_LEN_HI, S_DATA, S_CRC_LO, S_CRC_HI,
    S_READ, S_LOAD, S_SHOW
  } state_t;

  state_t state;
  logic   parsing;
  logic   take;
  logic   give;

  assign parsing   = (state != S_READ) && (state != S_LOAD) && (state != S_SHOW);
  assign in_stall  = !parsing;
  assign take      = in_valid && parsing;
  assign out_valid = (state == S_SHOW);
  assign give      = out_valid && !out_stall;

  always_comb begin
    cmd          = '0;
    cmd.crc_init = take && (state == S_SYNC) && sts.sync_hit;
    cmd.crc_upd  = take && ((state == S_CMD) || (state == S_SEQ) || (state == S_LEN_LO) ||
                            (state == S_LEN_HI) || (state == S_DATA));
    cmd.cap_cmd  = take && (state == S_CMD);
    cmd.cap_seq  = take && (state == S_SEQ);
    cmd.cap_len  = take && (state == S_LEN_LO);
    cmd.fill_clr = take && (state == S_LEN_HI);
    cmd.fill_wr  = take && (state == S_DATA);
    cmd.rel_clr  = take && (state == S_CRC_HI);
    cmd.rel_adv  = give && !sts.rel_last;
    cmd.out_load = (state == S_LOAD);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_SYNC;
    end else begin
      unique case (state)
        S_SYNC:   if (take && sts.sync_hit) state <= S_CMD;
        S_CMD:    if (take) state <= S_SEQ;
        S_SEQ:    if (take) state <= S_LEN_LO;
        S_LEN_LO: if (take) state <= S_LEN_HI;
        S_LEN_HI: begin
          if (take) begin
            if (sts.len_bad) begin
              state <= S_SYNC;
            end else if (sts.new_len_zero) begin
              state <= S_CRC_LO;
            end else begin
              state <= S_DATA;
            end
          end
        end
        S_DATA:   if (take && sts.fill_done) state <= S_CRC_LO;
        S_CRC_LO: if (take) state <= sts.crc_lo_ok ? S_CRC_HI : S_SYNC;
        S_CRC_HI: begin
          if (take) begin
            if (!sts.crc_hi_ok) begin
              state <= S_SYNC;
            end else if (sts.len_zero) begin
              state <= S_LOAD;
            end else begin
              state <= S_READ;
            end
          end
        end
        S_READ:   state <= S_LOAD;
        S_LOAD:   state <= S_SHOW;
        S_SHOW:   if (give) state <= sts.rel_last ? S_SYNC : S_READ;
        default:  state <= S_SYNC;
      endcase
    end
  end

endmodule

[rtl/crcdf_checker.sv]
// ----------------------------------------------------------------------------
// crcdf_checker
// Port-level checks for the deframer, bound to the top level.
// ----------------------------------------------------------------------------
module crcdf_checker
  import crcdf_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  in_valid,
  input logic                  in_stall,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic [LEN_W-1:0]      payload_length,
  input logic [ADDR_W-1:0]     byte_index,
  input logic [BYTE_W-1:0]     data,
  input logic                  last
);

  // No result beat right after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // Input side holds off while a result is pending
  a_stall_on_release: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input accepted during release");

  // A stalled beat keeps its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(data) && $stable(byte_index)
                                  && $stable(last)))
    else $error("stalled beat changed");

  // The last beat carries the final index of the frame
  a_last_index: assert property (@(posedge clk) disable iff (rst)
    (out_valid && last) |-> ((payload_length == '0) ||
                             (({1'b0, byte_index} + LEN_W'(1)) == payload_length)))
    else $error("last beat at wrong index");

  // Beats within a run advance the index by one
  a_index_step: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && !last) |-> ##3
      (out_valid && (byte_index == $past(byte_index, 3) + ADDR_W'(1))))
    else $error("byte index did not advance");

endmodule

bind crc16_packet_deframer crcdf_checker u_chk (.*);

[tb/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the CRC-16 packet deframer: drives framed byte
// streams (good, corrupted, oversized, truncated, noise) under random idling
// and stalls, predicts every result beat and checks each one as it arrives.
// ----------------------------------------------------------------------------
module tb;
  import crcdf_pkg::*;

  localparam int CLK_HALF      = 5;
  localparam int RESET_CYCLES  = 7;
  // Give the block ample time to go quiet after the last predicted beat.
  localparam int SETTLE_CYCLES = 16;
  // Worst case, every one of under 200 bytes releasing a full 64-beat run under
  // random stalls plus the long hold-off stays under this limit with a wide margin.
  localparam int CYCLE_LIMIT   = 200000;
  localparam int MAX_REPORTS   = 10;
  localparam int HOLD_CYCLES   = 300;

  // Receive phases of the frame parser
  typedef enum logic [2:0] {
    HUNT, GET_CMD, GET_SEQ, GET_LEN_LO, GET_LEN_HI, GET_DATA, GET_CRC_LO, GET_CRC_HI
  } rx_phase_e;

  // Shapes of frame the stimulus can build
  typedef enum int {
    FR_GOOD, FR_BAD_CRC_LO, FR_BAD_LO_SYNC, FR_BAD_CRC_HI, FR_OVERSIZE, FR_TRUNCATED
  } frame_kind_e;

  typedef struct packed {
    logic [BYTE_W-1:0] command;
    logic [BYTE_W-1:0] sequence_res;
    logic [LEN_W-1:0]  payload_length;
    logic [ADDR_W-1:0] byte_index;
    logic [BYTE_W-1:0] data;
    logic              last;
  } result_beat_t;

  // CRC-16/CCITT, one byte, MSB first
  function automatic logic [CRC_W-1:0] ccitt_byte(input logic [CRC_W-1:0] crc,
                                                  input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] c;
    c = crc ^ {b, 8'h00};
    repeat (8) begin
      c = c[CRC_W-1] ? ({c[CRC_W-2:0], 1'b0} ^ CRC_POLY) : {c[CRC_W-2:0], 1'b0};
    end
    return c;
  endfunction

  // --------------------------------------------------------------------------
  // Frame predictor and result checker
  // --------------------------------------------------------------------------
  class deframer_scoreboard;
    logic [BYTE_W-1:0] sync_value;
    logic [LEN_W-1:0]  max_length;
    rx_phase_e         phase;
    logic [BYTE_W-1:0] cmd_byte;
    logic [BYTE_W-1:0] seq_byte;
    logic [15:0]       frame_len;
    logic [CRC_W-1:0]  crc;
    logic [6:0]        fill;
    logic [BYTE_W-1:0] store [MAX_PAYLOAD];
    result_beat_t      due[$];
    int unsigned       mismatches;
    int unsigned       beats_seen;
    int unsigned       frames_released;
    int unsigned       bytes_taken;

    function new();
      sync_value      = SYNC_RESET;
      max_length      = MAX_LEN_RESET;
      phase           = HUNT;
      cmd_byte        = '0;
      seq_byte        = '0;
      frame_len       = '0;
      crc             = CRC_INIT;
      fill            = '0;
      mismatches      = 0;
      beats_seen      = 0;
      frames_released = 0;
      bytes_taken     = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      if (idx == REG_SYNC_VALUE) begin
        sync_value = val;
      end else if (idx == REG_MAX_LENGTH) begin
        max_length = val[LEN_W-1:0];
      end
    endfunction

    // Advance the parser by one accepted byte; queue the run of a good frame.
    function void take_byte(logic [BYTE_W-1:0] b);
      int unsigned  lim;
      int unsigned  n;
      int           i;
      result_beat_t r;
      bytes_taken++;
      case (phase)
        HUNT: begin
          if (b == sync_value) begin
            phase = GET_CMD;
            crc   = CRC_INIT;
          end
        end
        GET_CMD: begin
          cmd_byte = b;
          crc      = ccitt_byte(crc, b);
          phase    = GET_SEQ;
        end
        GET_SEQ: begin
          seq_byte = b;
          crc      = ccitt_byte(crc, b);
          phase    = GET_LEN_LO;
        end
        GET_LEN_LO: begin
          frame_len = {8'h00, b};
          crc       = ccitt_byte(crc, b);
          phase     = GET_LEN_HI;
        end
        GET_LEN_HI: begin
          frame_len[15:8] = b;
          crc  = ccitt_byte(crc, b);
          fill = '0;
          lim  = (max_length > MAX_PAYLOAD) ? MAX_PAYLOAD : max_length;
          if (frame_len > lim) begin
            phase = HUNT;
          end else if (frame_len == 0) begin
            phase = GET_CRC_LO;
          end else begin
            phase = GET_DATA;
          end
        end
        GET_DATA: begin
          if (fill < MAX_PAYLOAD) store[fill[ADDR_W-1:0]] = b;
          fill = fill + 7'd1;
          crc  = ccitt_byte(crc, b);
          if (fill >= frame_len) phase = GET_CRC_LO;
        end
        GET_CRC_LO: begin
          phase = (b == crc[7:0]) ? GET_CRC_HI : HUNT;
        end
        default: begin
          if (b == crc[15:8]) begin
            n = (frame_len == 0) ? 1 : frame_len;
            for (i = 0; i < n; i++) begin
              r.command        = cmd_byte;
              r.sequence_res   = seq_byte;
              r.payload_length = frame_len[LEN_W-1:0];
              r.byte_index     = i[ADDR_W-1:0];
              r.data           = (frame_len == 0) ? '0 : store[i];
              r.last           = (i == n - 1);
              due.push_back(r);
            end
            frames_released++;
          end
          phase = HUNT;
        end
      endcase
    endfunction

    function string beat_str(result_beat_t t);
      return $sformatf("cmd=%02h seq=%02h len=%0d idx=%0d data=%02h last=%0b",
                       t.command, t.sequence_res, t.payload_length, t.byte_index,
                       t.data, t.last);
    endfunction

    function void check_beat(result_beat_t got);
      result_beat_t want;
      beats_seen++;
      if (due.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("[%0t] result beat with nothing due: %s", $time, beat_str(got));
        return;
      end
      want = due.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("[%0t] result mismatch", $time);
          $display("  expected %s", beat_str(want));
          $display("  actual   %s", beat_str(got));
        end
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // DUT and stimulus signals
  // --------------------------------------------------------------------------
  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_stall;
  logic [BYTE_W-1:0]     rx_byte;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [BYTE_W-1:0]     command;
  logic [BYTE_W-1:0]     sequence_res;
  logic [LEN_W-1:0]      payload_length;
  logic [ADDR_W-1:0]     byte_index;
  logic [BYTE_W-1:0]     data;
  logic                  last;

  deframer_scoreboard sb;
  logic [BYTE_W-1:0]  payload_q[$];
  int                 idle_pct;
  int                 stall_pct;
  int                 hold_left = 0;
  int unsigned        cycle_count = 0;

  crc16_packet_deframer uut (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .rx_byte        (rx_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .command        (command),
    .sequence_res   (sequence_res),
    .payload_length (payload_length),
    .byte_index     (byte_index),
    .data           (data),
    .last           (last)
  );

  always #CLK_HALF clk = ~clk;

  // Watchdog: end the run if the block wedges.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d result beats still due",
               cycle_count, sb.due.size());
      $display("** crc16_packet_deframer: FAILED **");
      $finish;
    end
  end

  // Sample both channels at the rising edge; take the input beat first so a
  // byte and a result on the same edge are seen in order.
  always @(posedge clk) begin : watch
    result_beat_t got;
    if (!rst) begin
      if (in_valid && !in_stall) sb.take_byte(rx_byte);
      if (out_valid && !out_stall) begin
        got.command        = command;
        got.sequence_res   = sequence_res;
        got.payload_length = payload_length;
        got.byte_index     = byte_index;
        got.data           = data;
        got.last           = last;
        sb.check_beat(got);
      end
    end
  end

  // Receiver: random stalls, or a solid hold-off while hold_left counts down.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall = 1'b1;
      hold_left--;
    end else begin
      out_stall = ($urandom_range(99) < stall_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Driver tasks; each is entered and left at a falling edge
  // --------------------------------------------------------------------------

  // Offer one byte, idling at random first; hold it until taken. Valid is
  // left high on return so back-to-back beats need no extra toggle.
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    while ($urandom_range(99) < idle_pct) begin
      in_valid = 1'b0;
      rx_byte  = 8'($urandom);
      @(negedge clk);
    end
    in_valid = 1'b1;
    rx_byte  = b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // Drop valid and wait until every predicted beat has come out, then let
  // the block finish whatever it may still be doing.
  task automatic wait_drained();
    in_valid = 1'b0;
    while (sb.due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Write both registers on back-to-back cycles; block must be idle.
  task automatic program_regs(input logic [CFG_DATA_W-1:0] sync,
                              input logic [CFG_DATA_W-1:0] max_len);
    cfg_we    = 1'b1;
    cfg_index = REG_SYNC_VALUE;
    cfg_data  = sync;
    @(posedge clk);
    sb.write_reg(REG_SYNC_VALUE, sync);
    @(negedge clk);
    cfg_index = REG_MAX_LENGTH;
    cfg_data  = max_len;
    @(posedge clk);
    sb.write_reg(REG_MAX_LENGTH, max_len);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic fill_payload(input int unsigned n);
    payload_q.delete();
    repeat (n) begin
      // sprinkle sync bytes inside the payload now and then
      payload_q.push_back(($urandom_range(7) == 0) ? sb.sync_value : 8'($urandom));
    end
  endtask

  // Build and send one frame from payload_q (len_field only for oversize).
  task automatic send_frame(input frame_kind_e kind, input logic [BYTE_W-1:0] cmd,
                            input logic [BYTE_W-1:0] seq, input logic [15:0] len_field);
    logic [BYTE_W-1:0] bytes_q[$];
    logic [CRC_W-1:0]  crc;
    int unsigned       cut;
    if (kind != FR_OVERSIZE) len_field = 16'(payload_q.size());
    bytes_q.push_back(cmd);
    bytes_q.push_back(seq);
    bytes_q.push_back(len_field[7:0]);
    bytes_q.push_back(len_field[15:8]);
    if (kind != FR_OVERSIZE) begin
      foreach (payload_q[i]) bytes_q.push_back(payload_q[i]);
    end
    crc = CRC_INIT;
    foreach (bytes_q[i]) crc = ccitt_byte(crc, bytes_q[i]);
    case (kind)
      FR_GOOD: begin
        bytes_q.push_back(crc[7:0]);
        bytes_q.push_back(crc[15:8]);
      end
      FR_BAD_CRC_LO: begin
        bytes_q.push_back(crc[7:0] ^ 8'($urandom_range(1, 255)));
      end
      FR_BAD_LO_SYNC: begin
        // wrong low CRC byte, a sync byte unless the CRC's low byte is the sync; must not restart a frame
        bytes_q.push_back((crc[7:0] != sb.sync_value) ? sb.sync_value : ~crc[7:0]);
      end
      FR_BAD_CRC_HI: begin
        bytes_q.push_back(crc[7:0]);
        bytes_q.push_back(crc[15:8] ^ 8'($urandom_range(1, 255)));
      end
      FR_TRUNCATED: begin
        cut = $urandom_range(1, bytes_q.size());
        while (bytes_q.size() > cut) void'(bytes_q.pop_back());
      end
      default: begin
        // oversize: header only, the block drops back to hunting
      end
    endcase
    bytes_q.push_front(sb.sync_value);
    foreach (bytes_q[i]) send_byte(bytes_q[i]);
  endtask

  // Feed filler until the parser is hunting again, so config writes and
  // phase changes never land inside a frame.
  task automatic drain_to_hunt();
    while (sb.phase != HUNT) send_byte(~sb.sync_value);
  endtask

  // Mostly well-formed frames with random content, the rest broken or noise.
  task automatic run_random(input int unsigned budget);
    int unsigned start;
    int unsigned lim;
    int unsigned len;
    int unsigned roll;
    start = sb.bytes_taken;
    while (sb.bytes_taken - start < budget) begin
      lim  = (sb.max_length > MAX_PAYLOAD) ? MAX_PAYLOAD : sb.max_length;
      len  = $urandom_range(0, (lim < 8) ? lim : 8);
      roll = $urandom_range(99);
      fill_payload(len);
      if (roll < 55) begin
        send_frame(FR_GOOD, 8'($urandom), 8'($urandom), 16'h0);
      end else if (roll < 63) begin
        send_frame(FR_BAD_CRC_LO, 8'($urandom), 8'($urandom), 16'h0);
      end else if (roll < 68) begin
        send_frame(FR_BAD_LO_SYNC, 8'($urandom), 8'($urandom), 16'h0);
      end else if (roll < 76) begin
        send_frame(FR_BAD_CRC_HI, 8'($urandom), 8'($urandom), 16'h0);
      end else if (roll < 86) begin
        // just past the limit, or a nonzero high length byte
        send_frame(FR_OVERSIZE, 8'($urandom), 8'($urandom),
                   $urandom_range(1) ? 16'(lim + $urandom_range(1, 8))
                                     : {8'($urandom_range(1, 255)), 8'($urandom)});
      end else if (roll < 93) begin
        send_frame(FR_TRUNCATED, 8'($urandom), 8'($urandom), 16'h0);
      end else begin
        repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
      end
    end
    drain_to_hunt();
    wait_drained();
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    sb        = new();
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_index = REG_SYNC_VALUE;
    cfg_data  = '0;
    in_valid  = 1'b0;
    rx_byte   = '0;
    idle_pct  = 24;
    stall_pct = 24;
    repeat (RESET_CYCLES) @(negedge clk);
    rst = 1'b0;

    // Directed frames on the reset settings (sync 0xAA, limit 64).
    // Zero-length frame whose command equals the sync byte.
    payload_q.delete();
    send_frame(FR_GOOD, 8'hAA, 8'h00, 16'h0);
    // Short frame with extreme bytes in every field.
    payload_q.delete();
    payload_q.push_back(8'h00);
    payload_q.push_back(8'hFF);
    send_frame(FR_GOOD, 8'hFF, 8'hFF, 16'h0);
    // Bad low CRC byte equal to sync, after a payload that is itself sync.
    payload_q.delete();
    payload_q.push_back(8'hAA);
    send_frame(FR_BAD_LO_SYNC, 8'h00, 8'h01, 16'h0);
    // Length with a nonzero high byte.
    send_frame(FR_OVERSIZE, 8'h12, 8'h34, 16'h0100);
    wait_drained();

    // Calm stretch: no idling on either side.
    idle_pct  = 0;
    stall_pct = 0;
    run_random(16);
    idle_pct  = 24;
    stall_pct = 24;
    run_random(8);

    // Extremes: sync 0x00 and a zero length limit.
    program_regs(8'h00, 8'h00);
    run_random(6);

    // Sync 0xFF; a limit field beyond MAX_PAYLOAD clamps to it.
    program_regs(8'hFF, 8'hFF);
    send_frame(FR_OVERSIZE, 8'($urandom), 8'($urandom), 16'(MAX_PAYLOAD + 1));
    wait_drained();

    // Long receiver hold-off while frames keep coming: the full-size release
    // backs up and the input must stall.
    @(posedge clk);
    hold_left = HOLD_CYCLES;
    @(negedge clk);
    fill_payload(MAX_PAYLOAD);
    send_frame(FR_GOOD, 8'($urandom), 8'($urandom), 16'h0);
    fill_payload(2);
    send_frame(FR_GOOD, 8'($urandom), 8'($urandom), 16'h0);
    wait_drained();

    // Random settings to finish.
    program_regs(8'($urandom), 8'($urandom_range(1, MAX_PAYLOAD)));
    run_random(6);

    wait_drained();
    if (sb.due.size() != 0) begin
      $display("%0d result beats never arrived", sb.due.size());
    end
    $display("Covered %0d bytes, %0d good frames, %0d result beats, %0d mismatches",
             sb.bytes_taken, sb.frames_released, sb.beats_seen, sb.mismatches);
    $display("Sync 0xAA/0x00/0xFF/random, limits 64/0/clamped/random, long hold-off");
    if (sb.mismatches == 0 && sb.due.size() == 0) begin
      $display("** crc16_packet_deframer: PASSED **");
    end else begin
      $display("** crc16_packet_deframer: FAILED **");
    end
    $finish;
  end

endmodule

[crc16_packet_deframer.f]
rtl/crcdf_pkg.sv
rtl/crcdf_ram.sv
rtl/crcdf_dp.sv
rtl/crcdf_ctrl.sv
rtl/crc16_packet_deframer.sv
rtl/crcdf_checker.sv
tb/tb.sv
